// File: hdl/dual_button_multi_tap_decoder_assert.svh
// Assertion macros used by the checker file of the tap decoder.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef DUAL_BUTTON_MULTI_TAP_DECODER_ASSERT_SVH
`define DUAL_BUTTON_MULTI_TAP_DECODER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define DBMT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define DBMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/dbmt_pkg.sv
// Package of the dual-button tap decoder: widths, reset values, register
// indexes and command codes. No dependencies.
package dbmt_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CMD_W  = 4;
    localparam int IDX_W  = 2;
    localparam int MAX_RESULTS = 3;

    typedef logic [TIME_W-1:0] time_ms_t;
    typedef logic [CFG_W-1:0]  cfg_val_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [IDX_W-1:0]  cfg_idx_t;
    typedef logic [2:0]        side_cnt_t;
    typedef logic [1:0]        joint_cnt_t;
    typedef logic [1:0]        res_cnt_t;

    localparam cfg_idx_t REG_SYNC_WINDOW = 2'd0;
    localparam cfg_idx_t REG_MULTI_CLICK = 2'd1;
    localparam cfg_idx_t REG_TAP_TIMEOUT = 2'd2;

    localparam cfg_val_t SYNC_WINDOW_RST = 16'd120;
    localparam cfg_val_t MULTI_CLICK_RST = 16'd500;
    localparam cfg_val_t TAP_TIMEOUT_RST = 16'd3000;

    localparam side_cnt_t  SIDE_CNT_MAX  = 3'd7;
    localparam joint_cnt_t JOINT_CNT_MAX = 2'd3;

    localparam cmd_t CMD_NONE    = 4'd0;
    localparam cmd_t CMD_LEFT_1  = 4'd2;
    localparam cmd_t CMD_RIGHT_1 = 4'd3;
    localparam cmd_t CMD_JOINT_1 = 4'd4;
    localparam cmd_t CMD_JOINT_2 = 4'd5;
    localparam cmd_t CMD_LEFT_3  = 4'd6;
    localparam cmd_t CMD_RIGHT_2 = 4'd7;
    localparam cmd_t CMD_RIGHT_3 = 4'd8;
    localparam cmd_t CMD_LEFT_2  = 4'd9;
    localparam cmd_t CMD_MAX     = 4'd9;

endpackage

// File: hdl/dbmt_sample_if.sv
// Sample channel of the tap decoder: timestamp and both button levels.
// Depends on dbmt_pkg.
interface dbmt_sample_if;
    import dbmt_pkg::*;
    logic     valid;
    logic     ready;
    time_ms_t now_ms;
    logic     level_right;
    logic     level_left;
    modport source (output valid, now_ms, level_right, level_left, input ready);
    modport sink   (input valid, now_ms, level_right, level_left, output ready);
endinterface

// File: hdl/dbmt_result_if.sv
// Result channel of the tap decoder: command code and last-of-sample flag.
// Depends on dbmt_pkg.
interface dbmt_result_if;
    import dbmt_pkg::*;
    logic valid;
    logic ready;
    cmd_t command;
    logic is_last;
    modport source (output valid, command, is_last, input ready);
    modport sink   (input valid, command, is_last, output ready);
endinterface

// File: hdl/dbmt_cfg_if.sv
// Configuration write channel of the tap decoder: register index and data.
// Depends on dbmt_pkg.
interface dbmt_cfg_if;
    import dbmt_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    cfg_val_t data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/dual_button_multi_tap_decoder.sv
// A taken sample waits in the input register; its results then load the result buffer.
// Throughput: one sample per cycle while the result buffer is free; a sample with
// n results holds the result buffer until they are taken, so the next sample waits.
// Reset (rst_n low, async): gesture state and buffers clear, registers load
// sync window 120, multi-click 500, tap timeout 3000 ms.
module dual_button_multi_tap_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    dbmt_sample_if.sink          sample,
    dbmt_result_if.source        result,
    dbmt_cfg_if.sink             cfg
);
    import dbmt_pkg::*;

    // configuration
    cfg_val_t sync_window_reg, multi_click_reg, tap_timeout_reg;

    // input register
    logic     in_valid_reg;
    time_ms_t in_now_reg;
    logic     in_r_reg, in_l_reg;

    // gesture state
    logic       prev_right_reg, prev_left_reg, armed_right_reg, armed_left_reg;
    logic       sync_pending_reg;
    time_ms_t   sync_start_reg, right_time_reg, left_time_reg, joint_time_reg;
    side_cnt_t  right_taps_reg, left_taps_reg;
    joint_cnt_t joint_taps_reg;
    cmd_t       last_cmd_reg;

    logic       prev_right_next, prev_left_next, armed_right_next, armed_left_next;
    logic       sync_pending_next;
    time_ms_t   sync_start_next, right_time_next, left_time_next, joint_time_next;
    side_cnt_t  right_taps_next, left_taps_next;
    joint_cnt_t joint_taps_next;
    cmd_t       last_cmd_next;

    // result buffer
    cmd_t     res_buf_reg [MAX_RESULTS];
    res_cnt_t res_cnt_reg;
    cmd_t     res_buf_next [MAX_RESULTS];
    res_cnt_t res_cnt_next;

    cmd_t     emit_cmd [MAX_RESULTS];
    res_cnt_t emit_cnt;

    logic advance, out_take, buf_free;

    assign out_take = result.valid && result.ready;
    assign buf_free = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && result.ready);
    assign advance  = in_valid_reg && buf_free;

    assign sample.ready   = !in_valid_reg || advance;
    assign cfg.ready      = 1'b1;
    assign result.valid   = (res_cnt_reg != 2'd0);
    assign result.command = res_buf_reg[0];
    assign result.is_last = (res_cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_window_reg <= SYNC_WINDOW_RST;
            multi_click_reg <= MULTI_CLICK_RST;
            tap_timeout_reg <= TAP_TIMEOUT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SYNC_WINDOW: sync_window_reg <= cfg.data;
                REG_MULTI_CLICK: multi_click_reg <= cfg.data;
                REG_TAP_TIMEOUT: tap_timeout_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_now_reg <= sample.now_ms;
            in_r_reg   <= sample.level_right;
            in_l_reg   <= sample.level_left;
        end
    end

    always_comb
    begin
        time_ms_t d_sync;
        logic     in_win;
        prev_right_next   = prev_right_reg;
        prev_left_next    = prev_left_reg;
        armed_right_next  = armed_right_reg;
        armed_left_next   = armed_left_reg;
        sync_pending_next = sync_pending_reg;
        sync_start_next   = sync_start_reg;
        right_time_next   = right_time_reg;
        left_time_next    = left_time_reg;
        joint_time_next   = joint_time_reg;
        right_taps_next   = right_taps_reg;
        left_taps_next    = left_taps_reg;
        joint_taps_next   = joint_taps_reg;
        last_cmd_next     = last_cmd_reg;
        emit_cnt          = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            emit_cmd[i] = CMD_NONE;
        end

        // arm on release
        if (prev_right_reg && !in_r_reg)
        begin
            armed_right_next = 1'b1;
        end
        if (prev_left_reg && !in_l_reg)
        begin
            armed_left_next = 1'b1;
        end

        // count taps on press of an armed side
        if (!prev_right_reg && in_r_reg && armed_right_next)
        begin
            sync_pending_next = 1'b1;
            sync_start_next   = in_now_reg;
            if (right_taps_next != SIDE_CNT_MAX)
            begin
                right_taps_next = right_taps_next + 3'd1;
            end
            right_time_next  = in_now_reg;
            armed_right_next = 1'b0;
        end
        if (!prev_left_reg && in_l_reg && armed_left_next)
        begin
            sync_pending_next = 1'b1;
            sync_start_next   = in_now_reg;
            if (left_taps_next != SIDE_CNT_MAX)
            begin
                left_taps_next = left_taps_next + 3'd1;
            end
            left_time_next  = in_now_reg;
            armed_left_next = 1'b0;
        end

        // sync window
        d_sync = in_now_reg - sync_start_next;
        in_win = (d_sync <= {16'd0, sync_window_reg});
        if (sync_pending_next)
        begin
            if (in_r_reg && in_l_reg && in_win)
            begin
                if (joint_taps_next != JOINT_CNT_MAX)
                begin
                    joint_taps_next = joint_taps_next + 2'd1;
                end
                joint_time_next   = in_now_reg;
                right_taps_next   = 3'd0;
                left_taps_next    = 3'd0;
                sync_pending_next = 1'b0;
            end
            if (!in_win)
            begin
                sync_pending_next = 1'b0;
            end
        end

        // joint decode
        if ((joint_taps_next != 2'd0) && !in_r_reg && !in_l_reg
            && ((in_now_reg - joint_time_next) > {16'd0, multi_click_reg}))
        begin
            case (joint_taps_next)
                2'd1:    last_cmd_next = CMD_JOINT_1;
                2'd2:    last_cmd_next = CMD_JOINT_2;
                default: ;
            endcase
            emit_cmd[emit_cnt] = last_cmd_next;
            emit_cnt           = emit_cnt + 2'd1;
            joint_taps_next    = 2'd0;
        end

        // drop stale side counts while pressed
        if ((right_taps_next != 3'd0) && in_r_reg
            && ((in_now_reg - right_time_next) > {16'd0, tap_timeout_reg}))
        begin
            right_taps_next = 3'd0;
        end
        if ((left_taps_next != 3'd0) && in_l_reg
            && ((in_now_reg - left_time_next) > {16'd0, tap_timeout_reg}))
        begin
            left_taps_next = 3'd0;
        end

        // right decode
        if (!sync_pending_next && (right_taps_next != 3'd0) && !in_r_reg
            && ((in_now_reg - right_time_next) > {16'd0, multi_click_reg}))
        begin
            case (right_taps_next)
                3'd1:
                begin
                    last_cmd_next      = CMD_RIGHT_1;
                    emit_cmd[emit_cnt] = CMD_RIGHT_1;
                    emit_cnt           = emit_cnt + 2'd1;
                end
                3'd2:
                begin
                    last_cmd_next      = CMD_RIGHT_2;
                    emit_cmd[emit_cnt] = CMD_RIGHT_2;
                    emit_cnt           = emit_cnt + 2'd1;
                end
                3'd3:
                begin
                    last_cmd_next      = CMD_RIGHT_3;
                    emit_cmd[emit_cnt] = CMD_RIGHT_3;
                    emit_cnt           = emit_cnt + 2'd1;
                end
                default: ;
            endcase
            right_taps_next = 3'd0;
        end

        // left decode
        if (!sync_pending_next && (left_taps_next != 3'd0) && !in_l_reg
            && ((in_now_reg - left_time_next) > {16'd0, multi_click_reg}))
        begin
            case (left_taps_next)
                3'd1:
                begin
                    last_cmd_next      = CMD_LEFT_1;
                    emit_cmd[emit_cnt] = CMD_LEFT_1;
                    emit_cnt           = emit_cnt + 2'd1;
                end
                3'd2:
                begin
                    last_cmd_next      = CMD_LEFT_2;
                    emit_cmd[emit_cnt] = CMD_LEFT_2;
                    emit_cnt           = emit_cnt + 2'd1;
                end
                3'd3:
                begin
                    last_cmd_next      = CMD_LEFT_3;
                    emit_cmd[emit_cnt] = CMD_LEFT_3;
                    emit_cnt           = emit_cnt + 2'd1;
                end
                default: ;
            endcase
            left_taps_next = 3'd0;
        end

        prev_right_next = in_r_reg;
        prev_left_next  = in_l_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_right_reg   <= 1'b1;
            prev_left_reg    <= 1'b1;
            armed_right_reg  <= 1'b0;
            armed_left_reg   <= 1'b0;
            sync_pending_reg <= 1'b0;
            sync_start_reg   <= '0;
            right_time_reg   <= '0;
            left_time_reg    <= '0;
            joint_time_reg   <= '0;
            right_taps_reg   <= '0;
            left_taps_reg    <= '0;
            joint_taps_reg   <= '0;
            last_cmd_reg     <= CMD_NONE;
        end
        else if (advance)
        begin
            prev_right_reg   <= prev_right_next;
            prev_left_reg    <= prev_left_next;
            armed_right_reg  <= armed_right_next;
            armed_left_reg   <= armed_left_next;
            sync_pending_reg <= sync_pending_next;
            sync_start_reg   <= sync_start_next;
            right_time_reg   <= right_time_next;
            left_time_reg    <= left_time_next;
            joint_time_reg   <= joint_time_next;
            right_taps_reg   <= right_taps_next;
            left_taps_reg    <= left_taps_next;
            joint_taps_reg   <= joint_taps_next;
            last_cmd_reg     <= last_cmd_next;
        end
    end

    // load the buffer on advance, else shift out one item per take
    always_comb
    begin
        res_buf_next = res_buf_reg;
        res_cnt_next = res_cnt_reg;
        if (advance)
        begin
            res_buf_next = emit_cmd;
            res_cnt_next = emit_cnt;
        end
        else if (out_take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_buf_next[i] = res_buf_reg[i+1];
            end
            res_cnt_next = res_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_buf_reg <= res_buf_next;
    end

endmodule

// File: hdl/dbmt_checker.sv
// Port-level checks for the tap decoder, bound to the top level.
// Depends on dbmt_pkg and dual_button_multi_tap_decoder_assert.svh.
`include "dual_button_multi_tap_decoder_assert.svh"

module dbmt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input dbmt_pkg::cmd_t      res_command,
    input logic                res_is_last,
    input logic                cfg_valid,
    input logic                cfg_ready
);
    import dbmt_pkg::*;

    `DBMT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(res_command) && $stable(res_is_last), "stalled item changed")
    `DBMT_ASSERT_NEXT(a_res_burst, res_valid && res_ready && !res_is_last, res_valid,
        "gap inside the items of one sample")
    `DBMT_ASSERT_SAME(a_cmd_range, res_valid, res_command <= CMD_MAX, "command out of range")
    `DBMT_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind dual_button_multi_tap_decoder dbmt_checker u_dbmt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_command (result.command),
    .res_is_last (result.is_last),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready)
);
